[hw/rtl/hall_commutation_direction_detect_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef HALL_COMMUTATION_DIRECTION_DETECT_MACROS_SVH
`define HALL_COMMUTATION_DIRECTION_DETECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCDD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hcdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hcdd_pkg;

    localparam int CODE_W  = 3;
    localparam int PHASE_W = 16;
    localparam int DIR_W   = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic signed [DIR_W-1:0] dir_t;

    localparam dir_t DIR_UNKNOWN  = 2'sb00;
    localparam dir_t DIR_FORWARD  = 2'sb01;
    localparam dir_t DIR_BACKWARD = 2'sb11;

    localparam code_t CODE_OFF_LOW  = 3'd0;
    localparam code_t CODE_OFF_HIGH = 3'd7;

    localparam phase_t PHASE_OFF = 16'h0000;
    localparam phase_t PHASE_A   = 16'h3801;
    localparam phase_t PHASE_B   = 16'h3018;
    localparam phase_t PHASE_C   = 16'h3810;
    localparam phase_t PHASE_D   = 16'h3180;
    localparam phase_t PHASE_E   = 16'h3081;
    localparam phase_t PHASE_F   = 16'h3108;

    typedef struct packed {
        logic  valid;
        code_t code;
    } stage_t;

    typedef struct packed {
        phase_t phase_enable;
        dir_t   rotation_dir;
    } result_t;

    // Phase-enable word for a Hall code; the reverse table mirrors the forward one.
    function automatic phase_t phase_word(input logic reverse, input code_t code);
        code_t idx;
        phase_t word;
        idx = reverse ? (CODE_OFF_HIGH - code) : code;
        case (idx)
            3'd1:    word = PHASE_A;
            3'd2:    word = PHASE_B;
            3'd3:    word = PHASE_C;
            3'd4:    word = PHASE_D;
            3'd5:    word = PHASE_E;
            3'd6:    word = PHASE_F;
            default: word = PHASE_OFF;
        endcase
        if (code == CODE_OFF_LOW || code == CODE_OFF_HIGH) begin
            word = PHASE_OFF;
        end
        return word;
    endfunction

    // Successor in the Hall sequence 4, 6, 2, 3, 1, 5.
    function automatic code_t cycle_next(input code_t code);
        code_t res;
        case (code)
            3'd4:    res = 3'd6;
            3'd6:    res = 3'd2;
            3'd2:    res = 3'd3;
            3'd3:    res = 3'd1;
            3'd1:    res = 3'd5;
            3'd5:    res = 3'd4;
            default: res = CODE_OFF_LOW;
        endcase
        return res;
    endfunction

    // Predecessor in the Hall sequence.
    function automatic code_t cycle_prev(input code_t code);
        code_t res;
        case (code)
            3'd6:    res = 3'd4;
            3'd2:    res = 3'd6;
            3'd3:    res = 3'd2;
            3'd1:    res = 3'd3;
            3'd5:    res = 3'd1;
            3'd4:    res = 3'd5;
            default: res = CODE_OFF_LOW;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hcdd_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcdd_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire hcdd_pkg::code_t s_code,
    input  wire logic           advance,
    output hcdd_pkg::stage_t    stage
);
    import hcdd_pkg::*;

    logic  valid_reg, valid_next;
    code_t code_reg, code_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            code_next  = s_code;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign stage.valid = valid_reg;
    assign stage.code  = code_reg;

endmodule

`default_nettype wire

[hw/rtl/hcdd_dir_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcdd_dir_track (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire hcdd_pkg::code_t  code,
    input  wire logic             advance,
    output hcdd_pkg::dir_t        dir_next
);
    import hcdd_pkg::*;

    code_t hist0_reg, hist1_reg;
    dir_t  dir_reg;
    code_t fwd1, fwd2, bwd1, bwd2;
    logic  code_valid;

    always_comb begin
        fwd1 = cycle_next(code);
        fwd2 = cycle_next(fwd1);
        bwd1 = cycle_prev(code);
        bwd2 = cycle_prev(bwd1);
        code_valid = (code != CODE_OFF_LOW) && (code != CODE_OFF_HIGH);
        dir_next = dir_reg;
        if (code_valid) begin
            if (fwd1 == hist0_reg && fwd2 == hist1_reg) begin
                dir_next = DIR_FORWARD;
            end else if (bwd1 == hist0_reg && bwd2 == hist1_reg) begin
                dir_next = DIR_BACKWARD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist0_reg <= CODE_OFF_LOW;
            hist1_reg <= CODE_OFF_LOW;
            dir_reg   <= DIR_UNKNOWN;
        end else if (advance) begin
            hist0_reg <= code;
            hist1_reg <= hist0_reg;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hcdd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module hcdd_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire hcdd_pkg::result_t result,
    output logic                   out_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [hcdd_pkg::M_DATA_W-1:0] m_tdata
);
    import hcdd_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W - PHASE_W - DIR_W){1'b0}},
                       result_reg.rotation_dir, result_reg.phase_enable};

endmodule

`default_nettype wire

[hw/rtl/hall_commutation_direction_detect.sv]
`timescale 1ns / 1ps
`default_nettype none
// Six-step Hall commutation with rotation direction detection.
// The s_ channel takes one Hall code per request (tdata bits 2:0, C B A).
// The m_ channel returns one result per request: tdata bits 15:0 hold the
// phase-enable word and bits 17:16 the signed rotation direction
// (1 forward, -1 backward, 0 unknown); the upper bits are zero.
// The cfg_ channel writes reverse_mode in cfg_data; 1 picks the reverse table.
// It is always ready and should be written only while no request is in flight.
// A request passes through the input register, then through table lookup and
// direction compare into the result register, which raises m_tvalid.
// Throughput is one request per cycle while the receiver does not stall.
// Reset clears the Hall history, the direction and reverse_mode and empties
// both registers. When the receiver stalls, the result register holds its
// request and the input register still takes one more; further requests wait.
module hall_commutation_direction_detect (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // hall_code[2:0], zero padding
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // phase_enable[15:0], rotation_dir[17:16], zero padding
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import hcdd_pkg::*;

    stage_t  stage;
    result_t result;
    dir_t    dir_next;
    logic    out_ready;
    logic    advance;
    logic    reverse_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            reverse_mode_reg <= cfg_data;
        end
    end

    assign advance = stage.valid && out_ready;

    hcdd_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_code   (s_tdata[CODE_W-1:0]),
        .advance  (advance),
        .stage    (stage)
    );

    hcdd_dir_track u_dir_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .code     (stage.code),
        .advance  (advance),
        .dir_next (dir_next)
    );

    assign result.phase_enable = phase_word(reverse_mode_reg, stage.code);
    assign result.rotation_dir = dir_next;

    hcdd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/hcdd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "hall_commutation_direction_detect_macros.svh"

module hcdd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import hcdd_pkg::*;

    phase_t pe;
    dir_t   rd;
    logic   stalled;
    logic   dir_ok;
    logic   phase_ok;

    assign pe = m_tdata[PHASE_W-1:0];
    assign rd = m_tdata[PHASE_W+DIR_W-1:PHASE_W];

    assign stalled  = m_tvalid && !m_tready;
    assign dir_ok   = (rd == DIR_UNKNOWN) || (rd == DIR_FORWARD) || (rd == DIR_BACKWARD);
    assign phase_ok = (pe == PHASE_OFF) || (pe == PHASE_A) || (pe == PHASE_B) ||
                      (pe == PHASE_C) || (pe == PHASE_D) || (pe == PHASE_E) || (pe == PHASE_F);

    `HCDD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, stalled,
                      m_tvalid && $stable(m_tdata), "result changed while stalled")
    `HCDD_ASSERT_SAME(a_dir_legal, aclk, aresetn, m_tvalid, dir_ok, "illegal rotation direction")
    `HCDD_ASSERT_SAME(a_phase_legal, aclk, aresetn, m_tvalid, phase_ok, "illegal phase word")
    `HCDD_ASSERT_SAME(a_reset_empty, aclk, aresetn, $rose(aresetn),
                      !m_tvalid && s_tready, "block not empty after reset")

endmodule

bind hall_commutation_direction_detect hcdd_checker u_hcdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
